>>> rtl/core/rsi_pkg.sv
// Shared types and constants of the ray/sphere intersection pipeline.
// Used by every module under rtl/core; depends on nothing.
package rsi_pkg;

  localparam int OrgW   = 32;
  localparam int DirW   = 18;
  localparam int RadW   = 31;
  localparam int EpsW   = 16;
  localparam int DistW  = 32;
  localparam int DiscW  = 64;
  localparam int RootW  = 32;
  localparam int SqrtSteps = DiscW / 2;

  localparam int InDataW  = 152;
  localparam int OutDataW = 32;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = RadW;

  localparam logic [RadW-1:0] RadiusReset = RadW'(65536);
  localparam logic [EpsW-1:0] EpsReset    = EpsW'(66);

  localparam logic [DistW-1:0] DistMax = {1'b0, {(DistW-1){1'b1}}};
  localparam logic [DistW-1:0] DistMin = {1'b1, {(DistW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgRadius = 1'b0,
    CfgEps    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic vld;
    logic miss;
  } rsi_flags_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DistW-1:0] distance;
  } rsi_result_t;

endpackage

>>> rtl/core/rsi_front.sv
// Front pipeline: dot product, squared lengths, discriminant and its saturation.
// Nine stages, all advancing on adv_i; depends on rsi_pkg.
module rsi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   adv_i,
  input  logic                                   in_vld_i,
  input  logic signed [rsi_pkg::OrgW-1:0]        origin_x_i,
  input  logic signed [rsi_pkg::OrgW-1:0]        origin_y_i,
  input  logic signed [rsi_pkg::OrgW-1:0]        origin_z_i,
  input  logic signed [rsi_pkg::DirW-1:0]        dir_x_i,
  input  logic signed [rsi_pkg::DirW-1:0]        dir_y_i,
  input  logic signed [rsi_pkg::DirW-1:0]        dir_z_i,
  input  logic        [rsi_pkg::RadW-1:0]        radius_i,
  output rsi_pkg::rsi_flags_t                    flags_o,
  output logic signed [52-FRAC_BITS:0]           b_o,
  output logic        [rsi_pkg::DiscW-1:0]       disc_o
);

  localparam int Stages = 9;
  localparam int PrdW   = rsi_pkg::OrgW + rsi_pkg::DirW;
  localparam int DotW   = PrdW + 2;
  localparam int NegW   = DotW + 1;
  localparam int BW     = NegW - FRAC_BITS;
  localparam int LoW    = (BW + 1) / 2;
  localparam int HiW    = BW - LoW;
  localparam int SqBW   = 2 * BW;
  localparam int TotW   = ((SqBW > rsi_pkg::DiscW) ? SqBW : rsi_pkg::DiscW) + 1;
  localparam int DifW   = TotW + 1;
  localparam int OoW    = 2 * rsi_pkg::OrgW - 1;
  localparam int R2W    = 2 * rsi_pkg::RadW;

  logic [Stages-1:0] vld_q;

  logic signed [PrdW-1:0]         px_q, py_q, pz_q;
  logic        [OoW-1:0]          qx_q, qy_q, qz_q;
  logic        [R2W-1:0]          r2_1_q, r2_2_q, r2_3_q, r2_4_q, r2_5_q, r2_6_q;
  logic signed [DotW-1:0]         dot_q;
  logic        [rsi_pkg::DiscW-1:0] v2_2_q, v2_3_q, v2_4_q, v2_5_q, v2_6_q, v2_7_q;
  logic signed [BW-1:0]           b3_q, b4_q, b5_q, b6_q, b7_q, b8_q, b9_q;
  logic        [BW-1:0]           babs_q;
  logic        [2*LoW-1:0]        p00_q;
  logic        [LoW+HiW-1:0]      p01_q;
  logic        [2*HiW-1:0]        p11_q;
  logic        [SqBW-1:0]         sq_q;
  logic        [TotW-1:0]         tot_q;
  logic        [DifW-1:0]         diff_q;
  logic        [rsi_pkg::DiscW-1:0] disc_q;
  logic                           miss_q;

  logic signed [PrdW-1:0]         px_d, py_d, pz_d;
  logic signed [2*rsi_pkg::OrgW-1:0] qx_d, qy_d, qz_d;
  logic signed [NegW-1:0]         neg_d;
  logic        [LoW-1:0]          a0_d;
  logic        [HiW-1:0]          a1_d;
  logic        [SqBW-1:0]         sq_d;
  logic        [DifW-1:0]         diff_d;
  logic        [rsi_pkg::DiscW-1:0] disc_d;

  assign px_d  = origin_x_i * dir_x_i;
  assign py_d  = origin_y_i * dir_y_i;
  assign pz_d  = origin_z_i * dir_z_i;
  assign qx_d  = origin_x_i * origin_x_i;
  assign qy_d  = origin_y_i * origin_y_i;
  assign qz_d  = origin_z_i * origin_z_i;
  assign neg_d = -NegW'(dot_q);
  assign a0_d  = babs_q[LoW-1:0];
  assign a1_d  = babs_q[BW-1:LoW];
  assign sq_d  = SqBW'(p00_q) + (SqBW'(p01_q) << (LoW + 1)) + (SqBW'(p11_q) << (2 * LoW));
  assign diff_d = DifW'(tot_q) - DifW'(v2_7_q);
  assign disc_d = (|diff_q[DifW-2:rsi_pkg::DiscW]) ? {rsi_pkg::DiscW{1'b1}}
                                                  : diff_q[rsi_pkg::DiscW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[Stages-2:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
      qx_q   <= qx_d[OoW-1:0];
      qy_q   <= qy_d[OoW-1:0];
      qz_q   <= qz_d[OoW-1:0];
      r2_1_q <= radius_i * radius_i;

      dot_q  <= DotW'(px_q) + DotW'(py_q) + DotW'(pz_q);
      v2_2_q <= rsi_pkg::DiscW'(qx_q) + rsi_pkg::DiscW'(qy_q) + rsi_pkg::DiscW'(qz_q);
      r2_2_q <= r2_1_q;

      b3_q   <= BW'(neg_d >>> FRAC_BITS);
      v2_3_q <= v2_2_q;
      r2_3_q <= r2_2_q;

      b4_q   <= b3_q;
      babs_q <= b3_q[BW-1] ? BW'(-b3_q) : BW'(b3_q);
      v2_4_q <= v2_3_q;
      r2_4_q <= r2_3_q;

      b5_q   <= b4_q;
      p00_q  <= a0_d * a0_d;
      p01_q  <= a0_d * a1_d;
      p11_q  <= a1_d * a1_d;
      v2_5_q <= v2_4_q;
      r2_5_q <= r2_4_q;

      b6_q   <= b5_q;
      sq_q   <= sq_d;
      v2_6_q <= v2_5_q;
      r2_6_q <= r2_5_q;

      b7_q   <= b6_q;
      tot_q  <= TotW'(sq_q) + TotW'(r2_6_q);
      v2_7_q <= v2_6_q;

      b8_q   <= b7_q;
      diff_q <= diff_d;

      b9_q   <= b8_q;
      disc_q <= disc_d;
      miss_q <= diff_q[DifW-1];
    end
  end

  assign flags_o.vld  = vld_q[Stages-1];
  assign flags_o.miss = miss_q;
  assign b_o          = b9_q;
  assign disc_o       = disc_q;

endmodule

>>> rtl/core/rsi_sqrt_cell.sv
// One step of the integer square root chain: resolves one root bit per cell.
// Passes remainder, partial root and the ray's b to the next cell; depends on rsi_pkg.
module rsi_sqrt_cell #(
  parameter int STEP = 0,
  parameter int BW   = 37
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  rsi_pkg::rsi_flags_t               flags_i,
  input  logic signed [BW-1:0]              b_i,
  input  logic        [rsi_pkg::DiscW-1:0]  rem_i,
  input  logic        [rsi_pkg::DiscW-1:0]  res_i,
  output rsi_pkg::rsi_flags_t               flags_o,
  output logic signed [BW-1:0]              b_o,
  output logic        [rsi_pkg::DiscW-1:0]  rem_o,
  output logic        [rsi_pkg::DiscW-1:0]  res_o
);

  localparam logic [rsi_pkg::DiscW-1:0] StepBit =
    rsi_pkg::DiscW'(1) << (rsi_pkg::DiscW - 2 - 2 * STEP);

  rsi_pkg::rsi_flags_t              flags_q;
  logic signed [BW-1:0]             b_q;
  logic        [rsi_pkg::DiscW-1:0] rem_q, res_q;
  logic        [rsi_pkg::DiscW-1:0] try_d, rem_d, res_d;

  always_comb begin
    try_d = res_i + StepBit;
    if (rem_i >= try_d) begin
      rem_d = rem_i - try_d;
      res_d = (res_i >> 1) + StepBit;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (adv_i) begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_q   <= b_i;
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign flags_o = flags_q;
  assign b_o     = b_q;
  assign rem_o   = rem_q;
  assign res_o   = res_q;

endmodule

>>> rtl/core/rsi_out_fifo.sv
// Two-word output queue that decouples the pipeline from the result stream.
// Depends on rsi_pkg for the result word.
module rsi_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rsi_pkg::rsi_result_t data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rsi_pkg::rsi_result_t data_o
);

  rsi_pkg::rsi_result_t mem_q [2];
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;
  logic                 pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop)
    else $error("push into a full output queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

endmodule

>>> rtl/core/ray_sphere_intersect.sv
// Ray against a sphere of programmable radius centered at the origin, Q16.16 by default.
// One ray is accepted every cycle while the output queue has room. The path from
// input to output word runs through nine front stages (products, dot product, b,
// squares, discriminant and saturation), 32 square-root cells, one bit of the root
// each, two tail stages (root selection and clamping), and one stage in the two-word
// output queue. The root chain sets the latency. Write registers only while no ray is in flight.
module ray_sphere_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rsi_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rsi_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // origin_x, origin_y, origin_z (32 each), dir_x, dir_y, dir_z (18 each), 2 zero bits
  input  logic [rsi_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // hit_distance (32)
  output logic [rsi_pkg::OutDataW-1:0]      m_axis_tdata,
  // hit (1)
  output logic [0:0]                        m_axis_tuser
);

  localparam int BW    = 53 - FRAC_BITS;
  localparam int Steps = rsi_pkg::SqrtSteps;
  localparam int TW    = ((BW > rsi_pkg::RootW + 1) ? BW : rsi_pkg::RootW + 1) + 2;
  localparam int OrgW  = rsi_pkg::OrgW;
  localparam int DirW  = rsi_pkg::DirW;

  logic [rsi_pkg::RadW-1:0] radius_q;
  logic [rsi_pkg::EpsW-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rsi_pkg::RadiusReset;
      eps_q    <= rsi_pkg::EpsReset;
    end else if (cfg_we_i) begin
      unique case (rsi_pkg::cfg_reg_e'(cfg_idx_i))
        rsi_pkg::CfgRadius: radius_q <= cfg_data_i;
        rsi_pkg::CfgEps:    eps_q    <= cfg_data_i[rsi_pkg::EpsW-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic fifo_full;

  rsi_pkg::rsi_flags_t              flags_c [Steps+1];
  logic signed [BW-1:0]             b_c     [Steps+1];
  logic        [rsi_pkg::DiscW-1:0] rem_c   [Steps+1];
  logic        [rsi_pkg::DiscW-1:0] res_c   [Steps+1];

  rsi_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_vld_i   (s_axis_tvalid),
    .origin_x_i ($signed(s_axis_tdata[OrgW-1:0])),
    .origin_y_i ($signed(s_axis_tdata[2*OrgW-1:OrgW])),
    .origin_z_i ($signed(s_axis_tdata[3*OrgW-1:2*OrgW])),
    .dir_x_i    ($signed(s_axis_tdata[3*OrgW+DirW-1:3*OrgW])),
    .dir_y_i    ($signed(s_axis_tdata[3*OrgW+2*DirW-1:3*OrgW+DirW])),
    .dir_z_i    ($signed(s_axis_tdata[3*OrgW+3*DirW-1:3*OrgW+2*DirW])),
    .radius_i   (radius_q),
    .flags_o    (flags_c[0]),
    .b_o        (b_c[0]),
    .disc_o     (rem_c[0])
  );

  assign res_c[0] = '0;

  for (genvar k = 0; k < Steps; k++) begin : g_sqrt
    rsi_sqrt_cell #(
      .STEP (k),
      .BW   (BW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .flags_i (flags_c[k]),
      .b_i     (b_c[k]),
      .rem_i   (rem_c[k]),
      .res_i   (res_c[k]),
      .flags_o (flags_c[k+1]),
      .b_o     (b_c[k+1]),
      .rem_o   (rem_c[k+1]),
      .res_o   (res_c[k+1])
    );
  end

  rsi_pkg::rsi_flags_t   t1_flags_q, t2_flags_q;
  logic signed [TW-1:0]  tm_q, tp_q;
  logic signed [TW-1:0]  eps_ext, tsel_d;
  logic        [rsi_pkg::RootW-1:0] root;
  logic        [TW-rsi_pkg::DistW:0] top_bits;
  rsi_pkg::rsi_result_t  res_d, res_q, fifo_out;

  assign root    = res_c[Steps][rsi_pkg::RootW-1:0];
  assign eps_ext = TW'($signed({1'b0, eps_q}));
  assign tsel_d  = (tm_q < eps_ext) ? tp_q : tm_q;
  assign top_bits = tsel_d[TW-1:rsi_pkg::DistW-1];

  always_comb begin
    res_d.hit      = !t1_flags_q.miss;
    res_d.distance = '0;
    if (!t1_flags_q.miss) begin
      if ((&top_bits) || !(|top_bits)) begin
        res_d.distance = tsel_d[rsi_pkg::DistW-1:0];
      end else if (tsel_d[TW-1]) begin
        res_d.distance = rsi_pkg::DistMin;
      end else begin
        res_d.distance = rsi_pkg::DistMax;
      end
    end
  end

  assign adv           = !(t2_flags_q.vld && fifo_full);
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_flags_q <= '0;
      t2_flags_q <= '0;
    end else if (adv) begin
      t1_flags_q <= flags_c[Steps];
      t2_flags_q <= t1_flags_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tm_q  <= TW'(b_c[Steps]) - TW'(root);
      tp_q  <= TW'(b_c[Steps]) + TW'(root);
      res_q <= res_d;
    end
  end

  rsi_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (t2_flags_q.vld && adv),
    .data_i  (res_q),
    .full_o  (fifo_full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (fifo_out)
  );

  assign m_axis_tdata = fifo_out.distance;
  assign m_axis_tuser = fifo_out.hit;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss word carries a nonzero distance");

  a_root_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_c[Steps].vld |-> res_c[Steps][rsi_pkg::DiscW-1:rsi_pkg::RootW] == '0)
    else $error("square root exceeds its width");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t2_flags_q.vld && !adv |=> t2_flags_q.vld && $stable(res_q))
    else $error("tail word lost during stall");

endmodule

>>> sim/tb_ray_sphere_intersect.sv
// Self-checking testbench for ray_sphere_intersect: streams rays, predicts hit and distance.
// Depends on rsi_pkg and the ray_sphere_intersect RTL; needs no files or arguments.
module tb_ray_sphere_intersect;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits   = 16;
  localparam int One        = 65536;
  localparam int OrgMax     = 32'sh7FFF_FFFF;
  localparam int OrgMin     = 32'sh8000_0000;
  localparam int DirMax     = 131071;
  localparam int DirMin     = -131072;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 4000;
  localparam int PhaseRays  = 200;

  class dist_scoreboard;
    rsi_pkg::rsi_result_t pending[$];
    logic [rsi_pkg::RadW-1:0] radius;
    logic [rsi_pkg::EpsW-1:0] eps;
    int unsigned mismatches, words, hits, rays;

    function new();
      radius = rsi_pkg::RadiusReset;
      eps    = rsi_pkg::EpsReset;
    endfunction

    function void set_reg(rsi_pkg::cfg_reg_e idx, logic [rsi_pkg::CfgDataW-1:0] val);
      if (idx == rsi_pkg::CfgRadius) radius = val;
      else if (idx == rsi_pkg::CfgEps) eps = val[rsi_pkg::EpsW-1:0];
    endfunction

    function logic [31:0] root_floor(logic [63:0] x);
      logic [31:0] r, c;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        c = r | (32'd1 << i);
        if (64'(c) * 64'(c) <= x) r = c;
      end
      return r;
    endfunction

    function rsi_pkg::rsi_result_t predict(logic [rsi_pkg::InDataW-1:0] w);
      logic signed [31:0] ox, oy, oz;
      logic signed [17:0] dx, dy, dz;
      logic signed [63:0] dot, b;
      logic signed [127:0] b2, v2, r2, disc;
      logic [127:0] radw;
      logic [63:0] clipped;
      longint root, t;
      rsi_pkg::rsi_result_t res;
      ox = w[31:0];
      oy = w[63:32];
      oz = w[95:64];
      dx = w[113:96];
      dy = w[131:114];
      dz = w[149:132];
      res.hit      = 1'b0;
      res.distance = '0;
      dot  = ox * dx + oy * dy + oz * dz;
      b    = (-dot) >>> FracBits;
      b2   = b * b;
      v2   = ox * ox + oy * oy + oz * oz;
      radw = radius;
      r2   = radw * radw;
      disc = b2 + r2 - v2;
      if (disc < 0) return res;
      clipped = (disc[127:64] != '0) ? '1 : disc[63:0];
      root = longint'({32'b0, root_floor(clipped)});
      t = b - root;
      if (t < longint'({48'b0, eps})) t = b + root;
      res.hit = 1'b1;
      if (t > 64'sd2147483647) res.distance = rsi_pkg::DistMax;
      else if (t < -64'sd2147483648) res.distance = rsi_pkg::DistMin;
      else res.distance = 32'(t);
      return res;
    endfunction

    function void note_ray(logic [rsi_pkg::InDataW-1:0] w);
      pending.push_back(predict(w));
      rays++;
    endfunction

    function void check_word(logic hit, logic signed [31:0] distance);
      rsi_pkg::rsi_result_t exp_res;
      words++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word hit=%0b dist=%0d", $time, hit, distance);
        return;
      end
      exp_res = pending.pop_front();
      if (hit !== exp_res.hit || distance !== exp_res.distance) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected hit=%0b dist=%0d, got hit=%0b dist=%0d",
                   $time, exp_res.hit, exp_res.distance, hit, distance);
      end else if (hit) begin
        hits++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rsi_pkg::CfgIdxW-1:0] cfg_idx_i = rsi_pkg::CfgRadius;
  logic [rsi_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // origin_x, origin_y, origin_z (32 each), dir_x, dir_y, dir_z (18 each), 2 zero bits
  logic [rsi_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // hit_distance (32)
  logic [rsi_pkg::OutDataW-1:0] m_axis_tdata;
  // hit (1)
  logic [0:0] m_axis_tuser;

  dist_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  ray_sphere_intersect #(.FRAC_BITS(FracBits)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tuser[0], m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("ray_sphere_intersect verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [rsi_pkg::InDataW-1:0] pack_ray(
      input int ox, oy, oz, input int dx, dy, dz);
    return {2'b00, 18'(dz), 18'(dy), 18'(dx), 32'(oz), 32'(oy), 32'(ox)};
  endfunction

  function automatic logic signed [31:0] to_fixed(input real v);
    if (v >= 2147483647.0) return OrgMax;
    if (v <= -2147483648.0) return OrgMin;
    return $rtoi(v);
  endfunction

  function automatic logic [rsi_pkg::InDataW-1:0] random_ray(input real rad);
    real u[3];
    real norm, along, spread, r;
    int kind;
    logic signed [31:0] o[3];
    logic signed [17:0] d[3];
    kind = $urandom_range(99);
    r = (rad < 1.0) ? 65536.0 * $urandom_range(1, 64) : rad;
    if (kind < 65) begin
      norm = 0.0;
      while (norm < 0.05) begin
        for (int k = 0; k < 3; k++) u[k] = real'(int'($urandom_range(20000)) - 10000) / 10000.0;
        norm = $sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
      end
      along  = real'(int'($urandom_range(5000)) - 1000) / 1000.0 * r;
      spread = real'($urandom_range(1200)) / 1000.0 * r;
      for (int k = 0; k < 3; k++) begin
        o[k] = to_fixed(-along * u[k] / norm +
                        spread * real'(int'($urandom_range(2000)) - 1000) / 1000.0);
        d[k] = 18'(int'(u[k] / norm * 65536.0) + int'($urandom_range(4)) - 2);
      end
    end else if (kind < 85) begin
      for (int k = 0; k < 3; k++) begin
        o[k] = $signed($urandom) >>> $urandom_range(31);
        d[k] = 18'($urandom);
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        o[k] = $urandom;
        d[k] = 18'($urandom);
      end
    end
    return pack_ray(int'(o[0]), int'(o[1]), int'(o[2]),
                    int'(d[0]), int'(d[1]), int'(d[2]));
  endfunction

  task automatic send_ray(input logic [rsi_pkg::InDataW-1:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_ray(w);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input rsi_pkg::cfg_reg_e idx,
                           input logic [rsi_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  initial begin : main
    logic [rsi_pkg::RadW-1:0] rad;
    logic [rsi_pkg::EpsW-1:0] eps;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_ray(pack_ray(0, 0, -5 * One, 0, 0, One));
    send_ray(pack_ray(0, 0, 0, One, 0, 0));
    send_ray(pack_ray(0, 5 * One, -5 * One, 0, 0, One));
    send_ray(pack_ray(One, 0, -5 * One, 0, 0, One));
    send_ray(pack_ray(0, 0, 5 * One, 0, 0, One));
    send_ray(pack_ray(0, 0, -(One + 65), 0, 0, One));
    send_ray(pack_ray(0, 0, -(One + 66), 0, 0, One));
    send_ray(pack_ray(One, 0, 0, One, 0, 0));
    send_ray(pack_ray(3 * One, 4 * One, 0, 0, 0, 0));
    send_ray(pack_ray(0, 0, -2 * One, 0, 0, -One));
    send_ray(pack_ray(OrgMin, OrgMin, OrgMin, One, One, One));
    send_ray(pack_ray(OrgMax, OrgMax, OrgMax, DirMax, DirMax, DirMax));
    send_ray(pack_ray(OrgMax, OrgMin, OrgMax, DirMin, DirMax, DirMin));
    send_ray(pack_ray(OrgMin, OrgMax, OrgMin, -One, -One, -One));
    send_ray(pack_ray(0, 0, 0, DirMin, DirMin, DirMin));
    send_ray(pack_ray(-1, -1, -1, 1, 1, 1));
    send_ray(pack_ray(1, 1, 1, 1, 1, 1));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      case (p)
        1: begin rad = '0; eps = '0; end
        2: begin rad = '1; eps = '1; end
        3: begin rad = 31'($urandom_range(32'h0040_0000, 32'h0000_1000)); eps = '0; end
        4: begin rad = rsi_pkg::RadiusReset; eps = rsi_pkg::EpsReset; end
        5: begin rad = 31'($urandom); eps = 16'($urandom); end
        6: begin rad = 31'($urandom_range(One)); eps = '1; end
        default: begin
          rad = 31'($urandom_range(32'h0040_0000, 32'h0000_1000));
          eps = 16'($urandom);
        end
      endcase
      write_reg(rsi_pkg::CfgRadius, rad);
      write_reg(rsi_pkg::CfgEps, {15'($urandom), eps});
      if (p == 0) hold_seq = hold_seq + 1;
      for (int i = 0; i < PhaseRays; i++) begin
        if (p == 5 && i == PhaseRays / 2) wait_drained();
        send_ray(random_ray(real'(sb.radius)));
      end
      wait_drained();
    end

    repeat (60) @(posedge clk_i);
    $display("Covered %0d rays over 9 register settings and four idle patterns,",
             sb.rays);
    $display("%0d result words checked, %0d hits, %0d mismatches.",
             sb.words, sb.hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ray_sphere_intersect verification clean");
    end else begin
      $display("ray_sphere_intersect verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rsi_pkg.sv
rtl/core/rsi_front.sv
rtl/core/rsi_sqrt_cell.sv
rtl/core/rsi_out_fifo.sv
rtl/core/ray_sphere_intersect.sv
sim/tb_ray_sphere_intersect.sv
